>>> sv/sv39ptb_pkg.sv
// Shared constants for the Sv39 page table builder: sizes, item kinds, status codes, config register indices.
package sv39ptb_pkg;

	localparam int POOL_FRAMES       = 64;
	localparam int ENTRIES_PER_TABLE = 512;

	localparam int SLOT_W  = $clog2(POOL_FRAMES);
	localparam int VPN_W   = $clog2(ENTRIES_PER_TABLE);
	localparam int TIDX_W  = SLOT_W + VPN_W;
	localparam int TDEPTH  = POOL_FRAMES * ENTRIES_PER_TABLE;
	localparam int CNT_W   = $clog2(POOL_FRAMES + 1);
	localparam int PPN_W   = 44;
	localparam int PA_W    = 56;
	localparam int VA_W    = 39;
	localparam int PTE_W   = 64;
	localparam int SPAN_W  = VA_W + 2;

	localparam logic [1:0] KIND_FREE  = 2'd0;
	localparam logic [1:0] KIND_ROOT  = 2'd1;
	localparam logic [1:0] KIND_MAP   = 2'd2;
	localparam logic [1:0] KIND_TRANS = 2'd3;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_FREE   = 3'd1;
	localparam logic [2:0] ST_MAPPED     = 3'd2;
	localparam logic [2:0] ST_NO_FRAMES  = 3'd3;
	localparam logic [2:0] ST_NOT_MAPPED = 3'd4;
	localparam logic [2:0] ST_OVERFLOW   = 3'd5;
	localparam logic [2:0] ST_NO_ROOT    = 3'd6;

	localparam logic [1:0] REG_KERNEL_END = 2'd0;
	localparam logic [1:0] REG_PHYS_TOP   = 2'd1;

endpackage

>>> sv/sv39_page_table_builder.sv
// Sv39 page table builder and walker over a private table memory and free-frame stack.
//
//  channel   direction  handshake             payload
//  in        sink       in_valid / in_ready   kind virt_addr size_bytes phys_addr perm_bits
//  out       source     out_valid / out_ready status leaf_entry root_addr
//  cfg       sink       cfg_wr_en             cfg_index cfg_data
//
// Free checks the address and, if it is good and the stack has room, pushes the frame.
// Each table level is a table memory read, then a check; every table allocated is first
// cleared, all 512 of its entries, through the single table write port.
// Reset clears the stack count and the root; the memories are not cleared.
// A result waits in the output register; a new word is taken once the last is queued.
module sv39_page_table_builder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [38:0] virt_addr,
	input  logic [38:0] size_bytes,
	input  logic [55:0] phys_addr,
	input  logic [4:0]  perm_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [63:0] leaf_entry,
	output logic [55:0] root_addr,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [55:0] cfg_data
);

	localparam int SLOT_W = sv39ptb_pkg::SLOT_W;
	localparam int VPN_W  = sv39ptb_pkg::VPN_W;
	localparam int TIDX_W = sv39ptb_pkg::TIDX_W;
	localparam int CNT_W  = sv39ptb_pkg::CNT_W;
	localparam int PPN_W  = sv39ptb_pkg::PPN_W;
	localparam int PA_W   = sv39ptb_pkg::PA_W;
	localparam int PTE_W  = sv39ptb_pkg::PTE_W;
	localparam int SPAN_W = sv39ptb_pkg::SPAN_W;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_RD    = 3'd2;
	localparam logic [2:0] S_CHK   = 3'd3;
	localparam logic [2:0] S_POP   = 3'd4;
	localparam logic [2:0] S_CLR   = 3'd5;
	localparam logic [2:0] S_LINK  = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	localparam logic [SPAN_W-1:0] PAGE_STEP = SPAN_W'(4096);
	localparam logic [VPN_W-1:0]  VPN_LAST  = {VPN_W{1'b1}};

	logic [PTE_W-1:0] tbl_mem [sv39ptb_pkg::TDEPTH];
	logic [PPN_W-1:0] stk_mem [sv39ptb_pkg::POOL_FRAMES];

	logic [2:0]        state_q;
	logic [1:0]        kind_q;
	logic [SPAN_W-1:0] cur_q, stop_q;
	logic              sz_zero_q;
	logic [PA_W-1:0]   pa_q;
	logic [4:0]        perm_q;
	logic [1:0]        level_q;
	logic [PPN_W-1:0]  table_q, fr_q, root_frame_q;
	logic              root_present_q;
	logic [CNT_W-1:0]  free_count_q;
	logic [VPN_W-1:0]  clr_cnt_q;
	logic [TIDX_W-1:0] ent_idx_q;
	logic [2:0]        st_q;
	logic [PTE_W-1:0]  leaf_q;
	logic [PA_W-1:0]   kend_q, ptop_q;
	logic [PTE_W-1:0]  tbl_rd_q;
	logic [PPN_W-1:0]  stk_rd_q;
	logic              out_valid_q;
	logic [2:0]        status_q;
	logic [PTE_W-1:0]  leaf_entry_q;
	logic [PA_W-1:0]   root_addr_q;

	logic [VPN_W-1:0]  vpn;
	logic [TIDX_W-1:0] rd_idx;
	logic              tbl_we;
	logic [TIDX_W-1:0] tbl_wa;
	logic [PTE_W-1:0]  tbl_wd;
	logic              tbl_re;
	logic              stk_we, stk_re;
	logic [SLOT_W-1:0] stk_top;
	logic              free_bad;
	logic [SPAN_W-1:0] cur_next;
	logic              in_acc, out_load;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign cur_next = cur_q + PAGE_STEP;
	assign stk_top  = SLOT_W'(free_count_q - CNT_W'(1));

	always_comb begin
		case (level_q)
			2'd2:    vpn = cur_q[38:30];
			2'd1:    vpn = cur_q[29:21];
			default: vpn = cur_q[20:12];
		endcase
	end
	assign rd_idx = {table_q[SLOT_W-1:0], vpn};

	assign free_bad = (pa_q[11:0] != 12'd0) || (pa_q < kend_q) || (pa_q >= ptop_q);

	always_comb begin
		tbl_we = 1'b0;
		tbl_wa = ent_idx_q;
		tbl_wd = '0;
		tbl_re = (state_q == S_RD);
		stk_we = (state_q == S_START) && (kind_q == sv39ptb_pkg::KIND_FREE) && !free_bad &&
			(free_count_q < CNT_W'(sv39ptb_pkg::POOL_FRAMES));
		stk_re = 1'b0;
		unique case (state_q)
			S_START: stk_re = (kind_q == sv39ptb_pkg::KIND_ROOT) && (free_count_q != '0);
			S_CHK: begin
				if (level_q == 2'd0) begin
					tbl_we = (kind_q == sv39ptb_pkg::KIND_MAP) && !tbl_rd_q[0];
					tbl_wd = {10'd0, pa_q[55:12], 5'd0, perm_q | 5'd1};
				end else begin
					stk_re = !tbl_rd_q[0] && (kind_q == sv39ptb_pkg::KIND_MAP) &&
						(free_count_q != '0);
				end
			end
			S_CLR: begin
				tbl_we = 1'b1;
				tbl_wa = {fr_q[SLOT_W-1:0], clr_cnt_q};
			end
			S_LINK: begin
				tbl_we = (kind_q != sv39ptb_pkg::KIND_ROOT);
				tbl_wd = {10'd0, fr_q, 9'd0, 1'b1};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
		if (tbl_re) tbl_rd_q <= tbl_mem[rd_idx];
		if (stk_we) stk_mem[free_count_q[SLOT_W-1:0]] <= pa_q[55:12];
		if (stk_re) stk_rd_q <= stk_mem[stk_top];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kend_q <= '0;
			ptop_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				sv39ptb_pkg::REG_KERNEL_END: kend_q <= cfg_data;
				sv39ptb_pkg::REG_PHYS_TOP:   ptop_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q    <= kind;
			pa_q      <= phys_addr;
			perm_q    <= perm_bits;
			sz_zero_q <= (size_bytes == '0);
			stop_q    <= (SPAN_W'(virt_addr) + SPAN_W'(size_bytes) + SPAN_W'(4095)) &
				~SPAN_W'(4095);
			cur_q     <= (kind == sv39ptb_pkg::KIND_MAP) ?
				(SPAN_W'(virt_addr) & ~SPAN_W'(4095)) : SPAN_W'(virt_addr);
			leaf_q    <= '0;
		end
		case (state_q)
			S_START: begin
				table_q <= root_frame_q;
				level_q <= 2'd2;
			end
			S_RD: ent_idx_q <= rd_idx;
			S_CHK: begin
				if (level_q != 2'd0 && tbl_rd_q[0]) begin
					table_q <= tbl_rd_q[53:10];
					level_q <= level_q - 2'd1;
				end else if (level_q == 2'd0) begin
					if (kind_q == sv39ptb_pkg::KIND_TRANS) begin
						if (tbl_rd_q[0]) leaf_q <= tbl_rd_q;
					end else if (!tbl_rd_q[0]) begin
						pa_q    <= pa_q + PA_W'(4096);
						cur_q   <= cur_next;
						table_q <= root_frame_q;
						level_q <= 2'd2;
					end
				end
			end
			S_POP: begin
				fr_q      <= stk_rd_q;
				clr_cnt_q <= '0;
			end
			S_CLR: clr_cnt_q <= clr_cnt_q + VPN_W'(1);
			S_LINK: begin
				table_q <= fr_q;
				level_q <= level_q - 2'd1;
			end
			default: ;
		endcase
		if (out_load) begin
			status_q     <= st_q;
			leaf_entry_q <= leaf_q;
			root_addr_q  <= (kind_q == sv39ptb_pkg::KIND_ROOT && st_q == sv39ptb_pkg::ST_OK) ?
				{fr_q, 12'd0} : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			free_count_q   <= '0;
			root_frame_q   <= '0;
			root_present_q <= 1'b0;
			out_valid_q    <= 1'b0;
			st_q           <= sv39ptb_pkg::ST_OK;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (stk_we) free_count_q <= free_count_q + CNT_W'(1);
			if (stk_re) free_count_q <= free_count_q - CNT_W'(1);
			unique case (state_q)
				S_IDLE: if (in_acc) state_q <= S_START;
				S_START: begin
					case (kind_q)
						sv39ptb_pkg::KIND_FREE: begin
							state_q <= S_DONE;
							if (free_bad) st_q <= sv39ptb_pkg::ST_BAD_FREE;
							else if (!stk_we) st_q <= sv39ptb_pkg::ST_OVERFLOW;
							else st_q <= sv39ptb_pkg::ST_OK;
						end
						sv39ptb_pkg::KIND_ROOT: begin
							if (stk_re) begin
								st_q    <= sv39ptb_pkg::ST_OK;
								state_q <= S_POP;
							end else begin
								st_q    <= sv39ptb_pkg::ST_NO_FRAMES;
								state_q <= S_DONE;
							end
						end
						default: begin
							if (!root_present_q) begin
								st_q    <= sv39ptb_pkg::ST_NO_ROOT;
								state_q <= S_DONE;
							end else if (kind_q == sv39ptb_pkg::KIND_MAP && sz_zero_q) begin
								st_q    <= sv39ptb_pkg::ST_NOT_MAPPED;
								state_q <= S_DONE;
							end else begin
								st_q    <= sv39ptb_pkg::ST_OK;
								state_q <= S_RD;
							end
						end
					endcase
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					if (level_q != 2'd0) begin
						if (tbl_rd_q[0]) state_q <= S_RD;
						else if (kind_q == sv39ptb_pkg::KIND_TRANS) begin
							st_q    <= sv39ptb_pkg::ST_NOT_MAPPED;
							state_q <= S_DONE;
						end else if (stk_re) state_q <= S_POP;
						else begin
							st_q    <= sv39ptb_pkg::ST_NO_FRAMES;
							state_q <= S_DONE;
						end
					end else if (kind_q == sv39ptb_pkg::KIND_TRANS) begin
						if (!tbl_rd_q[0]) st_q <= sv39ptb_pkg::ST_NOT_MAPPED;
						state_q <= S_DONE;
					end else if (tbl_rd_q[0]) begin
						st_q    <= sv39ptb_pkg::ST_MAPPED;
						state_q <= S_DONE;
					end else begin
						state_q <= (cur_next == stop_q) ? S_DONE : S_RD;
					end
				end
				S_POP: state_q <= S_CLR;
				S_CLR: if (clr_cnt_q == VPN_LAST) state_q <= S_LINK;
				S_LINK: begin
					if (kind_q == sv39ptb_pkg::KIND_ROOT) begin
						root_frame_q   <= fr_q;
						root_present_q <= 1'b1;
						state_q        <= S_DONE;
					end else begin
						state_q <= S_RD;
					end
				end
				S_DONE: if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign leaf_entry = leaf_entry_q;
	assign root_addr  = root_addr_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_count_q <= CNT_W'(sv39ptb_pkg::POOL_FRAMES))
		else $error("free count past pool size");
	a_clear_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |=> state_q == S_CLR || state_q == S_LINK)
		else $error("clear pass left early");
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == S_START)
		else $error("accepted word not dispatched");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != sv39ptb_pkg::ST_OK |-> leaf_entry_q == '0 && root_addr_q == '0)
		else $error("error result carries data");

endmodule

>>> bench/sv39_page_table_builder_tb.sv
// Self-checking testbench for the Sv39 page table builder: directed table, then random items.
`timescale 1ns / 1ps

module sv39_page_table_builder_tb;

	localparam int LIMIT = 3000000;
	localparam logic [55:0] PA_MAX = 56'hFF_FFFF_FFFF_FFFF;
	localparam logic [38:0] VA_MAX = 39'h7F_FFFF_FFFF;

	typedef struct {
		logic [2:0]  st;
		logic [63:0] leaf;
		logic [55:0] root;
	} res_t;

	typedef struct {
		logic [1:0]  k;
		logic [38:0] va;
		logic [38:0] sz;
		logic [55:0] pa;
		logic [4:0]  perm;
		bit          typed;
		logic [2:0]  st;
	} row_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [1:0]  kind = '0;
	logic [38:0] virt_addr = '0;
	logic [38:0] size_bytes = '0;
	logic [55:0] phys_addr = '0;
	logic [4:0]  perm_bits = '0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [2:0]  status;
	logic [63:0] leaf_entry;
	logic [55:0] root_addr;
	logic        cfg_wr_en = 0;
	logic [1:0]  cfg_index = '0;
	logic [55:0] cfg_data = '0;

	sv39_page_table_builder i_dut (.*);

	always #4 clk = ~clk;

	// mirror of the block state
	logic [63:0] pt_mem [sv39ptb_pkg::TDEPTH];
	logic [43:0] frame_stack [sv39ptb_pkg::POOL_FRAMES];
	int          frame_cnt;
	logic [43:0] root_fr;
	bit          root_ok;
	logic [55:0] kend_reg, ptop_reg;

	res_t pending[$];
	int   errors = 0;
	int   cycles = 0;
	int   hold_reqs = 0;
	int   hold_taken = 0;
	int   hold_left = 0;
	int   stall_mode = 0;
	int   burst_left = 0;
	row_t dir[23];
	logic [38:0] regions[8];
	logic [38:0] last_va = '0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int slot_idx(logic [43:0] fr, logic [8:0] vpn);
		return int'(fr % sv39ptb_pkg::POOL_FRAMES) * sv39ptb_pkg::ENTRIES_PER_TABLE + int'(vpn);
	endfunction

	function automatic logic [8:0] vpn_at(logic [63:0] va, int lvl);
		return va[12 + 9 * lvl +: 9];
	endfunction

	function automatic bit take_frame(output logic [43:0] fr);
		fr = '0;
		if (frame_cnt == 0) return 0;
		frame_cnt--;
		fr = frame_stack[frame_cnt];
		return 1;
	endfunction

	function automatic void wipe_table(logic [43:0] fr);
		int base;
		base = slot_idx(fr, 9'd0);
		for (int i = 0; i < sv39ptb_pkg::ENTRIES_PER_TABLE; i++) pt_mem[base + i] = '0;
	endfunction

	function automatic logic [2:0] walk(logic [63:0] va, bit alloc, output int li);
		logic [43:0] t, fr;
		logic [63:0] e;
		int ix;
		li = 0;
		t = root_fr;
		for (int lvl = 2; lvl > 0; lvl--) begin
			ix = slot_idx(t, vpn_at(va, lvl));
			e = pt_mem[ix];
			if (e[0]) begin
				t = e[53:10];
			end else begin
				if (!alloc) return sv39ptb_pkg::ST_NOT_MAPPED;
				if (!take_frame(fr)) return sv39ptb_pkg::ST_NO_FRAMES;
				wipe_table(fr);
				pt_mem[ix] = {10'd0, fr, 10'd1};
				t = fr;
			end
		end
		li = slot_idx(t, vpn_at(va, 0));
		return sv39ptb_pkg::ST_OK;
	endfunction

	function automatic res_t predict_item(logic [1:0] k, logic [38:0] va, logic [38:0] sz,
			logic [55:0] pa, logic [4:0] perm);
		res_t r;
		logic [43:0] fr;
		logic [63:0] cur, stop;
		logic [2:0] s;
		int li;
		r = '{sv39ptb_pkg::ST_OK, '0, '0};
		if (k == sv39ptb_pkg::KIND_FREE) begin
			if (pa[11:0] != 0 || pa < kend_reg || pa >= ptop_reg) r.st = sv39ptb_pkg::ST_BAD_FREE;
			else if (frame_cnt >= sv39ptb_pkg::POOL_FRAMES) r.st = sv39ptb_pkg::ST_OVERFLOW;
			else begin
				frame_stack[frame_cnt] = pa[55:12];
				frame_cnt++;
			end
		end else if (k == sv39ptb_pkg::KIND_ROOT) begin
			if (!take_frame(fr)) r.st = sv39ptb_pkg::ST_NO_FRAMES;
			else begin
				wipe_table(fr);
				root_fr = fr;
				root_ok = 1;
				r.root = {fr, 12'd0};
			end
		end else if (!root_ok) begin
			r.st = sv39ptb_pkg::ST_NO_ROOT;
		end else if (k == sv39ptb_pkg::KIND_MAP) begin
			if (sz == 0) r.st = sv39ptb_pkg::ST_NOT_MAPPED;
			else begin
				cur = {25'd0, va[38:12], 12'd0};
				stop = (64'(va) + 64'(sz) + 64'd4095) & ~64'd4095;
				do begin
					s = walk(cur, 1, li);
					if (s != sv39ptb_pkg::ST_OK) begin
						r.st = s;
						break;
					end
					if (pt_mem[li][0]) begin
						r.st = sv39ptb_pkg::ST_MAPPED;
						break;
					end
					pt_mem[li] = {10'd0, pa[55:12], 5'd0, perm | 5'd1};
					pa = pa + 56'd4096;
					cur += 64'd4096;
				end while (cur != stop);
			end
		end else begin
			s = walk(64'(va), 0, li);
			if (s != sv39ptb_pkg::ST_OK) r.st = s;
			else if (!pt_mem[li][0]) r.st = sv39ptb_pkg::ST_NOT_MAPPED;
			else r.leaf = pt_mem[li];
		end
		return r;
	endfunction

	always @(posedge clk) begin
		res_t x;
		if (out_valid && out_ready) begin
			if (pending.size() == 0) begin
				$display("%0t unexpected word: status %0d leaf %h root %h", $time, status,
					leaf_entry, root_addr);
				errors++;
			end else begin
				x = pending.pop_front();
				if (status !== x.st) begin
					$display("%0t status exp %0d got %0d", $time, x.st, status);
					errors++;
				end
				if (leaf_entry !== x.leaf) begin
					$display("%0t leaf_entry exp %h got %h", $time, x.leaf, leaf_entry);
					errors++;
				end
				if (root_addr !== x.root) begin
					$display("%0t root_addr exp %h got %h", $time, x.root, root_addr);
					errors++;
				end
			end
		end
		if (hold_reqs != hold_taken && hold_left == 0) begin
			hold_taken = hold_reqs;
			hold_left = 3000;
		end
		if (cycles % 64 == 0) stall_mode = $urandom_range(0, 2);
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 0;
		end else if (stall_mode == 0) out_ready <= 1;
		else if (stall_mode == 1) out_ready <= 1'($urandom_range(0, 1));
		else out_ready <= ($urandom_range(0, 3) == 0);
	end

	task automatic send_word(logic [1:0] k, logic [38:0] va, logic [38:0] sz, logic [55:0] pa,
			logic [4:0] perm);
		in_valid <= 1;
		kind <= k;
		virt_addr <= va;
		size_bytes <= sz;
		phys_addr <= pa;
		perm_bits <= perm;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(1, 20);
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [55:0] v);
		cfg_wr_en <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_wr_en <= 0;
		if (idx == sv39ptb_pkg::REG_KERNEL_END) kend_reg = v;
		else ptop_reg = v;
	endtask

	task automatic run_one(bit hold);
		logic [1:0] k;
		logic [38:0] va, sz;
		logic [55:0] pa;
		logic [4:0] perm;
		int w;
		w = $urandom_range(0, 99);
		k = w < 40 ? sv39ptb_pkg::KIND_FREE : w < 45 ? sv39ptb_pkg::KIND_ROOT :
			w < 80 ? sv39ptb_pkg::KIND_MAP : sv39ptb_pkg::KIND_TRANS;
		perm = 5'($urandom);
		va = regions[$urandom_range(0, 7)] + 39'($urandom_range(0, 40) * 4096)
			+ 39'($urandom_range(0, 4095));
		if ($urandom_range(0, 9) == 0) va = 39'({$urandom, $urandom});
		sz = $urandom_range(0, 20) == 0 ? 39'd0 : 39'($urandom_range(1, 16 * 4096));
		if (frame_cnt == 0 && $urandom_range(0, 9) == 0) sz = 39'({$urandom, $urandom});
		pa = 56'({$urandom, $urandom});
		if (k == sv39ptb_pkg::KIND_FREE && $urandom_range(0, 9) != 0) begin
			pa = kend_reg + 56'($urandom_range(0, 4000) * 4096);
			pa[11:0] = '0;
		end
		if (k == sv39ptb_pkg::KIND_MAP) last_va = va;
		if (k == sv39ptb_pkg::KIND_TRANS && $urandom_range(0, 9) < 7)
			va = last_va + 39'($urandom_range(0, 8191));
		if (hold) hold_reqs++;
		pending.push_back(predict_item(k, va, sz, pa, perm));
		send_word(k, va, sz, pa, perm);
		pace();
	endtask

	task automatic run_phase(int n);
		for (int i = 0; i < n; i++) run_one(i == n / 2 && n >= 200);
	endtask

	initial begin
		res_t r;
		frame_cnt = 0;
		root_fr = '0;
		root_ok = 0;
		kend_reg = '0;
		ptop_reg = '0;
		for (int i = 0; i < 8; i++) regions[i] = 39'({$urandom, $urandom});
		dir[0]  = '{sv39ptb_pkg::KIND_MAP,   39'h0, 39'h1000, 56'h8010_0000, 5'h1E, 1,
			sv39ptb_pkg::ST_NO_ROOT};
		dir[1]  = '{sv39ptb_pkg::KIND_TRANS, 39'h0, 39'h0, 56'h0, 5'h0, 1,
			sv39ptb_pkg::ST_NO_ROOT};
		dir[2]  = '{sv39ptb_pkg::KIND_ROOT,  39'h0, 39'h0, 56'h0, 5'h0, 1,
			sv39ptb_pkg::ST_NO_FRAMES};
		dir[3]  = '{sv39ptb_pkg::KIND_FREE,  39'h0, 39'h0, 56'h8000_0001, 5'h0, 1,
			sv39ptb_pkg::ST_BAD_FREE};
		dir[4]  = '{sv39ptb_pkg::KIND_FREE,  39'h0, 39'h0, 56'h7FFF_F000, 5'h0, 1,
			sv39ptb_pkg::ST_BAD_FREE};
		dir[5]  = '{sv39ptb_pkg::KIND_FREE,  39'h0, 39'h0, 56'h8800_0000, 5'h0, 1,
			sv39ptb_pkg::ST_BAD_FREE};
		dir[6]  = '{sv39ptb_pkg::KIND_FREE,  39'h0, 39'h0, 56'h8000_0000, 5'h0, 1,
			sv39ptb_pkg::ST_OK};
		dir[7]  = '{sv39ptb_pkg::KIND_FREE,  39'h0, 39'h0, 56'h87FF_F000, 5'h0, 1,
			sv39ptb_pkg::ST_OK};
		dir[8]  = '{sv39ptb_pkg::KIND_FREE,  39'h0, 39'h0, 56'h8000_1000, 5'h0, 1,
			sv39ptb_pkg::ST_OK};
		dir[9]  = '{sv39ptb_pkg::KIND_FREE,  39'h0, 39'h0, 56'h8000_2000, 5'h0, 1,
			sv39ptb_pkg::ST_OK};
		dir[10] = '{sv39ptb_pkg::KIND_FREE,  39'h0, 39'h0, 56'h8000_3000, 5'h0, 1,
			sv39ptb_pkg::ST_OK};
		dir[11] = '{sv39ptb_pkg::KIND_FREE,  39'h0, 39'h0, 56'h8000_4000, 5'h0, 1,
			sv39ptb_pkg::ST_OK};
		dir[12] = '{sv39ptb_pkg::KIND_ROOT,  39'h0, 39'h0, 56'h0, 5'h0, 0, sv39ptb_pkg::ST_OK};
		dir[13] = '{sv39ptb_pkg::KIND_MAP,   39'h0, 39'h1, 56'h8010_0000, 5'h1E, 0,
			sv39ptb_pkg::ST_OK};
		dir[14] = '{sv39ptb_pkg::KIND_TRANS, 39'h0, 39'h0, 56'h0, 5'h0, 0, sv39ptb_pkg::ST_OK};
		dir[15] = '{sv39ptb_pkg::KIND_MAP,   39'h0, 39'h1, 56'h8020_0000, 5'h02, 0,
			sv39ptb_pkg::ST_OK};
		dir[16] = '{sv39ptb_pkg::KIND_MAP,   39'h0, 39'h0, 56'h0, 5'h1F, 1,
			sv39ptb_pkg::ST_NOT_MAPPED};
		dir[17] = '{sv39ptb_pkg::KIND_TRANS, 39'h7F_FFFF_F000, 39'h0, 56'h0, 5'h0, 0,
			sv39ptb_pkg::ST_OK};
		dir[18] = '{sv39ptb_pkg::KIND_MAP,   39'h7F_FFFF_F000, 39'h2000, 56'hFF_FFFF_FFFF_F000,
			5'h1F, 0, sv39ptb_pkg::ST_OK};
		dir[19] = '{sv39ptb_pkg::KIND_TRANS, 39'h7F_FFFF_FABC, 39'h0, 56'h0, 5'h0, 0,
			sv39ptb_pkg::ST_OK};
		dir[20] = '{sv39ptb_pkg::KIND_MAP,   39'h40_0000_0000, VA_MAX, PA_MAX, 5'h0A, 0,
			sv39ptb_pkg::ST_OK};
		dir[21] = '{sv39ptb_pkg::KIND_ROOT,  39'h0, 39'h0, 56'h0, 5'h0, 0, sv39ptb_pkg::ST_OK};
		dir[22] = '{sv39ptb_pkg::KIND_TRANS, 39'h0, 39'h0, 56'h0, 5'h0, 0, sv39ptb_pkg::ST_OK};
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		write_reg(sv39ptb_pkg::REG_KERNEL_END, 56'h8000_0000);
		write_reg(sv39ptb_pkg::REG_PHYS_TOP, 56'h8800_0000);
		foreach (dir[i]) begin
			r = predict_item(dir[i].k, dir[i].va, dir[i].sz, dir[i].pa, dir[i].perm);
			if (dir[i].typed) r = '{dir[i].st, '0, '0};
			pending.push_back(r);
			send_word(dir[i].k, dir[i].va, dir[i].sz, dir[i].pa, dir[i].perm);
			pace();
		end
		drain();
		run_phase(300);
		drain();
		write_reg(sv39ptb_pkg::REG_KERNEL_END, 56'h0);
		write_reg(sv39ptb_pkg::REG_PHYS_TOP, PA_MAX);
		run_phase(250);
		drain();
		write_reg(sv39ptb_pkg::REG_KERNEL_END, PA_MAX);
		write_reg(sv39ptb_pkg::REG_PHYS_TOP, 56'h0);
		run_phase(60);
		drain();
		write_reg(sv39ptb_pkg::REG_KERNEL_END, 56'h1_2345_6000);
		write_reg(sv39ptb_pkg::REG_PHYS_TOP, 56'h1_3000_0000);
		run_phase(200);
		drain();
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
